[rtl/vpa_pkg.sv]
`timescale 1ns / 1ps
package vpa_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int ADDR_BITS    = 16;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_BAD_STRAT = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_BAD_ARG   = 3'd5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] request_size;
    logic [1:0]  fit_strategy;
    logic [15:0] release_address;
    logic [5:0]  entry_index;
  } vpa_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] alloc_start;
    logic [15:0] entry_start;
    logic [15:0] entry_size;
    logic        entry_allocated;
    logic [6:0]  segment_count;
  } vpa_out_t;

endpackage

[rtl/variable_partition_allocator.sv]
`timescale 1ns / 1ps
// Variable partition allocator: address-ordered segment table (start, size,
// allocated) in one synchronous memory, always sorted and coalesced.
// Command channel: item accepted when start is high and busy is low. Opcode
// allocate (first/best/worst fit), release (merge with free neighbors) or
// read of one table entry. One result per item, shown for exactly one cycle
// with done high; the receiver cannot stall, so no result buffering exists.
// Configuration: cfg_we writes pool_size at any edge (table back to one free
// segment); write it only while no item is in flight.
// Flow: each item walks the table one entry a cycle through the memory
// read port (scan phase); an allocation split then shifts the tail up and a
// release merge shifts it down, one entry at a time, each entry read and
// then written (UPRD/UPWR, DNRD/DNWR). A read passes through READ and RDWT.
// Reset: pool_size returns to 1200, count to one; entry 0 is rewritten in
// the cycle after reset as a forced init (busy high meanwhile). No other entry
// needs clearing since entries at or beyond the count are never read.
module variable_partition_allocator
  import vpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  vpa_in_t  cmd,
  output logic     busy,
  input  logic     cfg_we,
  input  logic [15:0] cfg_data,
  output logic     done,
  output vpa_out_t result
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = 2 * ADDR_BITS + 1;
  localparam logic [15:0] POOL_RESET = 16'd1200;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_UPRD  = 4'd4;
  localparam logic [3:0] S_UPWR  = 4'd5;
  localparam logic [3:0] S_SPLIT = 4'd6;
  localparam logic [3:0] S_DNRD  = 4'd7;
  localparam logic [3:0] S_DNWR  = 4'd8;
  localparam logic [3:0] S_MERGE = 4'd9;
  localparam logic [3:0] S_READ  = 4'd10;
  localparam logic [3:0] S_RDWT  = 4'd11;

  // entry memory: {used, size, start}
  logic [EW-1:0] mem [MAX_SEGMENTS];
  logic [EW-1:0] rdata;
  logic [IW-1:0] raddr, waddr;
  logic [EW-1:0] wdata;
  logic          we;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [3:0]    state;
  logic [15:0]   pool_size;
  logic [CW-1:0] count;
  vpa_in_t       req;
  // result registers; the segment count comes straight from count
  logic [2:0]    out_status;
  logic [15:0]   out_alloc;
  logic [15:0]   out_estart;
  logic [15:0]   out_esize;
  logic          out_used;
  // scan pointers
  logic [CW-1:0] rptr;       // next address issued
  logic          rvalid;     // rdata holds entry rptr-1
  logic [IW-1:0] ridx;
  logic          found;
  logic [IW-1:0] pick;
  logic [EW-1:0] pick_e;
  logic          prev_free;  // entry before current is free
  logic [EW-1:0] prev_e;
  logic          have_prev;
  logic          have_next;
  logic [EW-1:0] next_e;
  logic [EW-1:0] prev_of_pick;
  logic          pick_prev_free;
  logic          rel_locked;  // release hit found, capture following entry
  logic [CW-1:0] mv;         // shift pointer
  logic [CW-1:0] merge_n;    // entries removed

  wire [ADDR_BITS-1:0] r_start = rdata[ADDR_BITS-1:0];
  wire [ADDR_BITS-1:0] r_size  = rdata[2*ADDR_BITS-1:ADDR_BITS];
  wire                 r_used  = rdata[EW-1];
  wire [ADDR_BITS-1:0] p_size  = pick_e[2*ADDR_BITS-1:ADDR_BITS];
  wire [ADDR_BITS-1:0] rq      = ADDR_BITS'(req.request_size);

  assign busy = (state != S_IDLE);

  always_comb begin
    raddr = rptr[IW-1:0];
    if (state == S_UPRD) raddr = IW'(mv - 1'b1);
    if (state == S_DNRD) raddr = IW'(mv + merge_n);
    if (state == S_READ) raddr = req.entry_index[IW-1:0];
    if (state == S_IDLE) raddr = cmd.entry_index[IW-1:0];
  end

  task automatic finish(input logic [2:0] st, input logic [15:0] as_);
    done <= 1'b1;
    out_status <= st;
    out_alloc <= as_;
    out_estart <= '0;
    out_esize <= '0;
    out_used <= 1'b0;
    state <= S_IDLE;
  endtask

  always_ff @(posedge clk) begin
    we <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= S_INIT;
      pool_size <= POOL_RESET;
      count <= CW'(1);
      rvalid <= 1'b0;
    end else if (cfg_we) begin
      pool_size <= cfg_data;
      count <= CW'(1);
      state <= S_INIT;
    end else begin
      unique case (state)
        S_INIT: begin
          we <= 1'b1;
          waddr <= '0;
          wdata <= {1'b0, ADDR_BITS'(pool_size), {ADDR_BITS{1'b0}}};
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req <= cmd;
            rptr <= '0;
            rvalid <= 1'b0;
            found <= 1'b0;
            prev_free <= 1'b0;
            have_prev <= 1'b0;
            have_next <= 1'b0;
            rel_locked <= 1'b0;
            if (cmd.opcode == OP_ALLOC) begin
              if (cmd.fit_strategy > FIT_WORST) finish(ST_BAD_STRAT, '0);
              else if (cmd.request_size == '0) finish(ST_BAD_ARG, '0);
              else state <= S_SCAN;
            end else if (cmd.opcode == OP_RELEASE) begin
              state <= S_SCAN;
            end else if (cmd.opcode == OP_READ &&
                         {1'b0, cmd.entry_index} < 7'(count) &&
                         32'(cmd.entry_index) < MAX_SEGMENTS) begin
              state <= S_READ;
            end else begin
              finish(ST_BAD_ARG, '0);
            end
          end
        end
        S_READ: state <= S_RDWT;
        S_RDWT: begin
          done <= 1'b1;
          out_status <= ST_OK;
          out_alloc <= '0;
          out_estart <= 16'(r_start);
          out_esize <= 16'(r_size);
          out_used <= r_used;
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (rptr < count) rptr <= rptr + 1'b1;
          rvalid <= (rptr < count);
          ridx <= rptr[IW-1:0];
          if (rvalid) begin
            if (req.opcode == OP_ALLOC) begin
              if (!r_used && !found &&
                  (req.fit_strategy != FIT_FIRST || r_size >= rq) &&
                  (req.fit_strategy != FIT_BEST || r_size >= rq)) begin
                found <= 1'b1; pick <= ridx; pick_e <= rdata;
              end else if (!r_used && found && req.fit_strategy == FIT_BEST &&
                           r_size >= rq && r_size < p_size) begin
                pick <= ridx; pick_e <= rdata;
              end else if (!r_used && found && req.fit_strategy == FIT_WORST &&
                           r_size > p_size) begin
                pick <= ridx; pick_e <= rdata;
              end
            end else begin
              if (rel_locked && !have_next) begin
                have_next <= 1'b1; next_e <= rdata;
              end else if (!rel_locked && r_used &&
                           r_start == ADDR_BITS'(req.release_address)) begin
                rel_locked <= 1'b1; found <= 1'b1; pick <= ridx; pick_e <= rdata;
                pick_prev_free <= have_prev && prev_free;
                prev_of_pick <= prev_e;
              end
              have_prev <= 1'b1; prev_free <= !r_used; prev_e <= rdata;
            end
          end
          if (!rvalid && rptr == count && rptr != '0) state <= S_DEC;
          if (req.opcode == OP_ALLOC && req.fit_strategy == FIT_FIRST && found)
            state <= S_DEC;
        end
        S_DEC: begin
          if (req.opcode == OP_ALLOC) begin
            if (!found || p_size < rq) finish(ST_NO_SPACE, '0);
            else if (p_size == rq) begin
              we <= 1'b1; waddr <= pick;
              wdata <= {1'b1, pick_e[EW-2:0]};
              finish(ST_OK, 16'(pick_e[ADDR_BITS-1:0]));
            end else if (32'(count) >= MAX_SEGMENTS) finish(ST_FULL, '0);
            else begin
              mv <= count;
              state <= (count > CW'(pick) + 1'b1) ? S_UPRD : S_SPLIT;
            end
          end else if (!found) begin
            finish(ST_NOT_FOUND, '0);
          end else begin
            // merged entry lands at base; merge_n entries vanish
            merge_n <= CW'(pick_prev_free) + CW'(have_next && !next_e[EW-1]);
            if (pick_prev_free) begin
              mv <= CW'(pick);
              waddr <= IW'(pick - 1'b1);
              wdata <= {1'b0, ADDR_BITS'(prev_of_pick[2*ADDR_BITS-1:ADDR_BITS] + p_size +
                        ((have_next && !next_e[EW-1]) ?
                          next_e[2*ADDR_BITS-1:ADDR_BITS] : '0)),
                        prev_of_pick[ADDR_BITS-1:0]};
            end else begin
              mv <= CW'(pick) + 1'b1;
              waddr <= pick;
              wdata <= {1'b0, ADDR_BITS'(p_size +
                        ((have_next && !next_e[EW-1]) ?
                          next_e[2*ADDR_BITS-1:ADDR_BITS] : '0)),
                        pick_e[ADDR_BITS-1:0]};
            end
            we <= 1'b1;
            state <= S_DNRD;
          end
        end
        S_UPRD: state <= S_UPWR;
        S_UPWR: begin
          we <= 1'b1; waddr <= mv[IW-1:0]; wdata <= rdata;
          mv <= mv - 1'b1;
          state <= (mv - 1'b1 > CW'(pick) + 1'b1) ? S_UPRD : S_SPLIT;
        end
        S_SPLIT: begin
          we <= 1'b1; waddr <= IW'(pick + 1'b1);
          wdata <= {1'b0, ADDR_BITS'(p_size - rq),
                    ADDR_BITS'(pick_e[ADDR_BITS-1:0] + rq)};
          state <= S_MERGE;
          mv <= '0;
          merge_n <= '0;
        end
        S_DNRD: begin
          if (merge_n == '0 || mv + merge_n >= count) begin
            count <= count - merge_n;
            finish(ST_OK, '0);
          end else state <= S_DNWR;
        end
        S_DNWR: begin
          we <= 1'b1; waddr <= mv[IW-1:0]; wdata <= rdata;
          mv <= mv + 1'b1;
          state <= S_DNRD;
        end
        S_MERGE: begin
          // finish split: shrink picked hole into the granted entry
          we <= 1'b1; waddr <= pick;
          wdata <= {1'b1, rq, pick_e[ADDR_BITS-1:0]};
          count <= count + 1'b1;
          finish(ST_OK, 16'(pick_e[ADDR_BITS-1:0]));
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result = {out_status, out_alloc, out_estart, out_esize, out_used, 7'(count)};

endmodule
